@@ src/edd_pkg.sv @@
// Package for the error diffusion dither: sizes, register indexes and the
// share and saturating add helpers. No dependencies.
package edd_pkg;

  localparam int unsigned MAX_WIDTH = 2048;
  localparam int unsigned ADDR_W    = $clog2(MAX_WIDTH);
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned DIM_W     = 12;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);
  localparam logic [DIM_W-1:0] WIDTH_LIMIT  = DIM_W'(MAX_WIDTH);

  localparam logic [PIX_W-1:0] THRESHOLD = 8'd127;
  localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;
  localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;

  localparam logic [2:0] WT_RIGHT      = 3'd7;
  localparam logic [2:0] WT_DOWN_RIGHT = 3'd1;
  localparam logic [2:0] WT_DOWN       = 3'd5;
  localparam logic [2:0] WT_DOWN_LEFT  = 3'd3;

  typedef enum logic {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_e;

  // One pixel in the execute stage, with its position decoded at accept.
  typedef struct packed {
    logic [PIX_W-1:0]  gray;
    logic [ADDR_W-1:0] col;
    logic              above;
    logic              first_col;
    logic              last_col;
    logic              last_row;
    logic              has_ur;
  } stage_t;

  // Weighted sixteenth of an error, truncated toward zero.
  function automatic logic signed [7:0] share(input logic signed [7:0] e,
                                              input logic [2:0] wt);
    logic signed [11:0] ex;
    logic signed [11:0] wx;
    logic signed [11:0] p;
    ex = 12'(e);
    wx = $signed(12'(wt));
    p  = ex * wx;
    if (p < 0) begin
      p = p + 12'sd15;
    end
    return 8'(p >>> 4);
  endfunction

  // Add a signed share to a pixel, clamped to 0..255.
  function automatic logic [7:0] sat_add(input logic [7:0] v,
                                         input logic signed [7:0] d);
    logic signed [9:0] s;
    s = $signed({2'b00, v}) + 10'(d);
    if (s > 10'sd255) begin
      return 8'd255;
    end else if (s < 10'sd0) begin
      return 8'd0;
    end
    return s[7:0];
  endfunction

endpackage

@@ src/edd_if.sv @@
// Valid/ready channel interfaces of the error diffusion dither.
// Depends on edd_pkg for field widths.
interface edd_pix_if;
  logic                     valid;
  logic                     ready;
  logic [edd_pkg::PIX_W-1:0] gray_pixel;
  modport source (output valid, output gray_pixel, input ready);
  modport sink   (input valid, input gray_pixel, output ready);
endinterface

interface edd_res_if;
  logic                     valid;
  logic                     ready;
  logic [edd_pkg::PIX_W-1:0] dithered_pixel;
  logic                     frame_end;
  modport source (output valid, output dithered_pixel, output frame_end, input ready);
  modport sink   (input valid, input dithered_pixel, input frame_end, output ready);
endinterface

interface edd_cfg_if;
  logic                     valid;
  logic                     ready;
  edd_pkg::cfg_idx_e        index;
  logic [edd_pkg::DIM_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/error_diffusion_dither.sv @@
// Top level of the error diffusion dither: error line memory, execute stage
// and output register. Depends on edd_pkg and the interfaces in edd_if.sv.
//
// Gray pixels enter in raster order and leave as 0 or 255 with frame_end set
// on the last pixel of the frame. A sustained rate of one pixel per clock
// holds for any frame size without back-pressure; each pixel passes the stage
// and output registers in turn. The pace is set by the error line memory, a
// 2048 x 8 synchronous RAM with one write and one read each clock: at accept
// the pixel reads the upper-right error of the previous row, and in the
// execute stage it writes its own diffused error back at its column. The
// error directly above comes from the read of the previous pixel, so one
// read per pixel suffices; a read that hits the write of the same edge is
// forwarded. The output register lets a new pixel enter while a result waits.
// image_width (index 0, 3..2048) and image_height (index 1) must be written
// by the user only while idle, unchecked by the block; the configuration
// channel is always ready. No clearing pass is needed after reset.
module error_diffusion_dither (
  input  logic          clk_i,
  input  logic          rst_ni,
  edd_pix_if.sink       pix_i,
  edd_res_if.source     res_o,
  edd_cfg_if.sink       cfg_i
);

  logic [edd_pkg::DIM_W-1:0]  width_q, height_q;
  logic [edd_pkg::ADDR_W-1:0] col_q, col_d;
  logic [edd_pkg::DIM_W-1:0]  row_q, row_d;

  logic                       stg_vld_q;
  edd_pkg::stage_t            stg_q, stg_d;
  logic                       out_vld_q;
  logic [edd_pkg::PIX_W-1:0]  out_pix_q;
  logic                       out_end_q;

  logic [7:0] left_q, ul_q, up_prev_q;
  logic [7:0] mem_rd_q, fwd_data_q;
  logic       fwd_hit_q;
  logic [7:0] err_mem [edd_pkg::MAX_WIDTH];

  logic                       accept, exec;
  logic [edd_pkg::DIM_W-1:0]  w_eff, h_eff, col_ext;
  logic [edd_pkg::ADDR_W-1:0] rd_addr;
  logic [7:0]                 ur_err, old_up, e_bits;
  logic [7:0]                 v0, v1, v2, v3, v4;
  logic signed [8:0]          err;
  logic                       diffuse, white;

  // Execute when the output register is free or is being emptied.
  assign exec         = stg_vld_q && (!out_vld_q || res_o.ready);
  assign pix_i.ready  = !stg_vld_q || exec;
  assign accept       = pix_i.valid && pix_i.ready;
  assign cfg_i.ready  = 1'b1;

  assign res_o.valid          = out_vld_q;
  assign res_o.dithered_pixel = out_pix_q;
  assign res_o.frame_end      = out_end_q;

  // Decode the position of the incoming pixel with the clamped frame size.
  always_comb begin
    w_eff = width_q;
    if (width_q == '0) begin
      w_eff = edd_pkg::DIM_W'(1);
    end else if (width_q > edd_pkg::WIDTH_LIMIT) begin
      w_eff = edd_pkg::WIDTH_LIMIT;
    end
    h_eff = (height_q == '0) ? edd_pkg::DIM_W'(1) : height_q;
    col_ext = edd_pkg::DIM_W'(col_q);

    stg_d.gray      = pix_i.gray_pixel;
    stg_d.col       = col_q;
    stg_d.above     = (row_q != '0);
    stg_d.first_col = (col_q == '0);
    stg_d.last_col  = (col_ext >= w_eff - edd_pkg::DIM_W'(1));
    stg_d.last_row  = (row_q >= h_eff - edd_pkg::DIM_W'(1));
    stg_d.has_ur    = (col_ext + edd_pkg::DIM_W'(1) < w_eff);

    // Read one column ahead; the wrap past the last column is never used.
    rd_addr = col_q + edd_pkg::ADDR_W'(1);

    col_d = col_q;
    row_d = row_q;
    if (stg_d.last_col) begin
      col_d = '0;
      row_d = stg_d.last_row ? '0 : row_q + edd_pkg::DIM_W'(1);
    end else begin
      col_d = col_q + edd_pkg::ADDR_W'(1);
    end
  end

  // Execute stage: gather the neighbor shares, threshold, and form the error.
  always_comb begin
    ur_err = fwd_hit_q ? fwd_data_q : mem_rd_q;
    // Column zero of every row always stored zero.
    old_up = stg_q.first_col ? 8'd0 : up_prev_q;

    v0 = stg_q.gray;
    v1 = (stg_q.above && !stg_q.first_col)
         ? edd_pkg::sat_add(v0, edd_pkg::share(ul_q, edd_pkg::WT_DOWN_RIGHT)) : v0;
    v2 = stg_q.above
         ? edd_pkg::sat_add(v1, edd_pkg::share(old_up, edd_pkg::WT_DOWN)) : v1;
    v3 = (stg_q.above && stg_q.has_ur)
         ? edd_pkg::sat_add(v2, edd_pkg::share(ur_err, edd_pkg::WT_DOWN_LEFT)) : v2;
    v4 = !stg_q.first_col
         ? edd_pkg::sat_add(v3, edd_pkg::share(left_q, edd_pkg::WT_RIGHT)) : v3;

    white = (v4 > edd_pkg::THRESHOLD);
    err   = white ? $signed({1'b0, v4}) - 9'sd255 : $signed({1'b0, v4});

    diffuse = !stg_q.last_row && !stg_q.first_col && !stg_q.last_col;
    e_bits  = diffuse ? err[7:0] : 8'd0;
  end

  // Error line memory with a registered read; forward a same-edge write.
  always_ff @(posedge clk_i) begin
    if (exec) begin
      err_mem[stg_q.col] <= e_bits;
    end
    if (accept) begin
      mem_rd_q   <= err_mem[rd_addr];
      fwd_hit_q  <= exec && (stg_q.col == rd_addr);
      fwd_data_q <= e_bits;
    end
  end

  // Payload of the stage and output registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_q <= stg_d;
    end
    if (exec) begin
      out_pix_q <= white ? edd_pkg::PIX_WHITE : edd_pkg::PIX_BLACK;
      out_end_q <= stg_q.last_col && stg_q.last_row;
    end
  end

  // Control state, counters, carried errors and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= edd_pkg::WIDTH_RESET;
      height_q  <= edd_pkg::HEIGHT_RESET;
      col_q     <= '0;
      row_q     <= '0;
      stg_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      left_q    <= '0;
      ul_q      <= '0;
      up_prev_q <= '0;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          edd_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_i.data;
          edd_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_i.data;
          default: ;
        endcase
      end
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (accept) begin
        stg_vld_q <= 1'b1;
      end else if (exec) begin
        stg_vld_q <= 1'b0;
      end
      if (exec) begin
        out_vld_q <= 1'b1;
        left_q    <= e_bits;
        ul_q      <= old_up;
        up_prev_q <= ur_err;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

endmodule

@@ dv/error_diffusion_dither_checker.sv @@
// Checker for the error diffusion dither: watches the pixel, result and
// configuration channels, predicts every dithered beat and compares it.
// Depends on edd_pkg and the channel interfaces in edd_if.sv.
module error_diffusion_dither_checker
  import edd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  edd_pix_if   pix_i,
  edd_res_if   res_i,
  edd_cfg_if   cfg_i,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    logic [PIX_W-1:0] dithered_pixel;
    logic             frame_end;
  } dither_beat_t;

  dither_beat_t            dither_expect_q[$];
  logic signed [PIX_W-1:0] row_err [MAX_WIDTH];
  logic signed [PIX_W-1:0] left_err;
  logic signed [PIX_W-1:0] upleft_err;
  logic [DIM_W-1:0]        width_q;
  logic [DIM_W-1:0]        height_q;
  logic [ADDR_W-1:0]       col_q;
  logic [DIM_W-1:0]        row_q;
  int                      fails;

  // Sixteenths of a signed error, truncated toward zero.
  function automatic int weighted(input logic signed [PIX_W-1:0] e, input logic [2:0] wt);
    return (int'(e) * int'(wt)) / 16;
  endfunction

  function automatic int clamp_add(input int v, input int d);
    int s;
    s = v + d;
    if (s > int'(PIX_WHITE)) return int'(PIX_WHITE);
    if (s < 0) return 0;
    return s;
  endfunction

  task automatic dither_pixel(input logic [PIX_W-1:0] gray);
    int                      w;
    int                      h;
    int                      c;
    int                      r;
    int                      v;
    int                      err;
    logic                    last_c;
    logic                    last_r;
    logic                    above;
    logic                    diffuse;
    logic signed [PIX_W-1:0] up;
    logic signed [PIX_W-1:0] eb;
    dither_beat_t            beat;
    w = (width_q == '0) ? 1 : (width_q > WIDTH_LIMIT) ? int'(MAX_WIDTH) : int'(width_q);
    h = (height_q == '0) ? 1 : int'(height_q);
    c = int'(col_q);
    r = int'(row_q);
    last_c = (c >= w - 1);
    last_r = (r >= h - 1);
    above  = (r != 0);
    v  = int'(gray);
    up = row_err[c];
    if (above && c >= 1) v = clamp_add(v, weighted(upleft_err, WT_DOWN_RIGHT));
    if (above) v = clamp_add(v, weighted(up, WT_DOWN));
    if (above && c + 1 < w) v = clamp_add(v, weighted(row_err[c+1], WT_DOWN_LEFT));
    if (c >= 1) v = clamp_add(v, weighted(left_err, WT_RIGHT));
    if (v > int'(THRESHOLD)) begin
      beat.dithered_pixel = PIX_WHITE;
      err = v - int'(PIX_WHITE);
    end else begin
      beat.dithered_pixel = PIX_BLACK;
      err = v;
    end
    beat.frame_end = last_c && last_r;
    // Edge pixels and the last row leave zero error behind.
    diffuse    = !last_r && c != 0 && !last_c;
    eb         = diffuse ? PIX_W'(err) : '0;
    upleft_err = up;
    row_err[c] = eb;
    left_err   = eb;
    if (last_c) begin
      col_q = '0;
      row_q = last_r ? '0 : DIM_W'(r + 1);
    end else begin
      col_q = ADDR_W'(c + 1);
    end
    dither_expect_q = {dither_expect_q, beat};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dither_beat_t want;
    if (!rst_ni) begin
      width_q    = WIDTH_RESET;
      height_q   = HEIGHT_RESET;
      col_q      = '0;
      row_q      = '0;
      left_err   = '0;
      upleft_err = '0;
      foreach (row_err[k]) row_err[k] = '0;
      dither_expect_q.delete();
      fails        = 0;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_IMAGE_WIDTH:  width_q  = cfg_i.data;
          CFG_IMAGE_HEIGHT: height_q = cfg_i.data;
          default: ;
        endcase
      end
      if (pix_i.valid && pix_i.ready) dither_pixel(pix_i.gray_pixel);
      if (res_i.valid && res_i.ready) begin
        if (dither_expect_q.size() == 0) begin
          $error("result beat with no pixel waiting: dithered_pixel %0d frame_end %0b",
                 res_i.dithered_pixel, res_i.frame_end);
          fails++;
        end else begin
          want = dither_expect_q.pop_front();
          if (res_i.dithered_pixel !== want.dithered_pixel) begin
            $error("dithered_pixel mismatch: expected %0d, actual %0d",
                   want.dithered_pixel, res_i.dithered_pixel);
            fails++;
          end
          if (res_i.frame_end !== want.frame_end) begin
            $error("frame_end mismatch: expected %0b, actual %0b",
                   want.frame_end, res_i.frame_end);
            fails++;
          end
        end
      end
      pending_o    = dither_expect_q.size();
      fail_count_o = fails;
    end
  end

endmodule

@@ dv/error_diffusion_dither_tb.sv @@
// Top of the error diffusion dither testbench: clock, reset, pixel stimulus,
// result back-pressure and the verdict. Depends on edd_pkg, edd_if.sv, the
// block and error_diffusion_dither_checker.
module error_diffusion_dither_tb;
  import edd_pkg::*;

  logic clk_i;
  logic rst_ni;

  edd_pix_if pix ();
  edd_res_if res ();
  edd_cfg_if cfg ();

  error_diffusion_dither dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  int fail_count;
  int pending;

  error_diffusion_dither_checker dither_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_i        (pix),
    .res_i        (res),
    .cfg_i        (cfg),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Idle odds in percent for each side, changed between test phases.
  int src_idle_pct;
  int snk_idle_pct;
  // Beats moved on each side; equal means the block holds nothing.
  int pixels_sent;
  int results_taken;
  // Ask the receiver for one long hold-off.
  bit stall_request;
  // Mirror of the block's position, so config changes never read stale
  // error entries: a width raise past written_cols is allowed only in row 0.
  int cur_w;
  int cur_h;
  int pos_col;
  int pos_row;
  int written_cols;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake hangs.
  initial begin
    #3000000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int eff_width(input int w);
    if (w == 0) return 1;
    if (w > int'(MAX_WIDTH)) return int'(MAX_WIDTH);
    return w;
  endfunction

  function automatic int eff_height(input int h);
    return (h == 0) ? 1 : h;
  endfunction

  // Pixels from the current position through the end of the frame.
  function automatic int frame_left();
    int w;
    int h;
    int in_row;
    w = eff_width(cur_w);
    h = eff_height(cur_h);
    in_row = (pos_col >= w - 1) ? 1 : w - pos_col;
    return in_row + ((pos_row >= h - 1) ? 0 : (h - 1 - pos_row) * w);
  endfunction

  // Bias toward the threshold and the rails, where saturation and the
  // black/white decision are most likely to go wrong.
  function automatic logic [PIX_W-1:0] pick_gray();
    case ($urandom_range(9))
      6, 7:    return PIX_W'($urandom_range(137, 118));
      8:       return $urandom_range(1) ? PIX_WHITE : PIX_BLACK;
      9:       return $urandom_range(1) ? PIX_W'(254) : PIX_W'(1);
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  // Offer one pixel, idling at random first; hold valid high when the next
  // pixel follows directly so it is never dropped and raised in one step.
  task automatic send_pixel(input logic [PIX_W-1:0] gray);
    int w;
    int h;
    while ($urandom_range(99) < src_idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix.valid      <= 1'b1;
    pix.gray_pixel <= gray;
    do @(posedge clk_i); while (!pix.ready);
    pixels_sent++;
    if (pos_col + 1 > written_cols) written_cols = pos_col + 1;
    w = eff_width(cur_w);
    h = eff_height(cur_h);
    if (pos_col >= w - 1) begin
      pos_col = 0;
      pos_row = (pos_row >= h - 1) ? 0 : pos_row + 1;
    end else begin
      pos_col++;
    end
  endtask

  // Drop the pixel valid, drain the block, then write both registers.
  task automatic set_config(input int w, input int h);
    pix.valid <= 1'b0;
    while (results_taken != pixels_sent) @(posedge clk_i);
    cfg.valid <= 1'b1;
    cfg.index <= CFG_IMAGE_WIDTH;
    cfg.data  <= DIM_W'(w);
    do @(posedge clk_i); while (!cfg.ready);
    cfg.index <= CFG_IMAGE_HEIGHT;
    cfg.data  <= DIM_W'(h);
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    cur_w = w;
    cur_h = h;
  endtask

  // Mostly whole frames of small size with random content; now and then a
  // partial frame, so settings also change mid-frame.
  task automatic run_random(input int n);
    int done;
    int len;
    int left;
    int wv;
    int hv;
    int pick;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(99);
      wv = cur_w;
      hv = cur_h;
      if (pick < 65) begin
        wv = $urandom_range(24, 3);
        hv = $urandom_range(8, 1);
      end else if (pick < 73) begin
        wv = $urandom_range(2);
        hv = $urandom_range(6, 1);
      end else if (pick < 79) begin
        wv = $urandom_range(200, 25);
        hv = $urandom_range(3, 1);
      end else if (pick < 84) begin
        case ($urandom_range(3))
          0:       wv = 2047;
          1:       wv = 2048;
          2:       wv = 4095;
          default: wv = $urandom_range(4094, 2049);
        endcase
        hv = $urandom_range(2, 1);
      end else if (pick < 89) begin
        wv = $urandom_range(16, 3);
        hv = $urandom_range(1) ? 4095 : 0;
      end
      // otherwise keep the settings and stream on
      if (pos_row != 0 && eff_width(wv) > written_cols) wv = written_cols;
      if (wv != cur_w || hv != cur_h) set_config(wv, hv);
      left = frame_left();
      if ($urandom_range(3) != 0) begin
        len = left;
        if (left < 40 && $urandom_range(1)) len += eff_width(cur_w) * eff_height(cur_h);
      end else begin
        len = $urandom_range(40, 1);
      end
      if (len > 300) len = 300;
      if (len > n - done) len = n - done;
      repeat (len) send_pixel(pick_gray());
      done += len;
    end
  endtask

  // Receiver: count accepted result beats from pre-edge values and drive
  // ready at random, or hold it low for the requested long stretch.
  initial begin
    int hold;
    hold = 0;
    res.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (res.valid && res.ready) results_taken++;
      if (stall_request) begin
        stall_request = 1'b0;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  initial begin
    logic [PIX_W-1:0] corner_px [9];
    rst_ni         = 1'b0;
    pix.valid      = 1'b0;
    pix.gray_pixel = '0;
    cfg.valid      = 1'b0;
    cfg.index      = CFG_IMAGE_WIDTH;
    cfg.data       = '0;
    src_idle_pct   = 31;
    snk_idle_pct   = 60;
    pixels_sent    = 0;
    results_taken  = 0;
    stall_request  = 1'b0;
    cur_w          = int'(WIDTH_RESET);
    cur_h          = int'(HEIGHT_RESET);
    pos_col        = 0;
    pos_row        = 0;
    written_cols   = 0;
    corner_px = '{8'd0, 8'd255, 8'd127, 8'd128, 8'd128, 8'd127, 8'd255, 8'd0, 8'd200};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Smallest legal frame: first row, right column, last row and the
    // threshold neighbors all in nine pixels.
    set_config(3, 3);
    foreach (corner_px[k]) send_pixel(corner_px[k]);
    // Zero width and height act as a one-pixel frame: every beat ends one.
    set_config(0, 0);
    send_pixel(PIX_BLACK);
    send_pixel(PIX_WHITE);
    // Width two: no column ever diffuses.
    set_config(2, 2);
    send_pixel(8'd128);
    send_pixel(8'd127);
    send_pixel(PIX_WHITE);
    send_pixel(8'd1);
    // Oversized settings, then a mid-frame shrink that puts the column count
    // past the new last column and wraps the frame from there.
    set_config(4095, 4095);
    send_pixel(8'd170);
    send_pixel(8'd85);
    send_pixel(PIX_WHITE);
    send_pixel(PIX_BLACK);
    set_config(3, 2);
    repeat (6) send_pixel(pick_gray());

    run_random(510);
    src_idle_pct = 60;
    snk_idle_pct = 31;
    run_random(510);
    // No idling; hold the receiver off while pixels keep coming, so the
    // block backs up into its input before any drain for a new setting.
    src_idle_pct = 0;
    snk_idle_pct = 0;
    stall_request = 1'b1;
    repeat (24) send_pixel(pick_gray());
    run_random(481);

    // Drain and let any stray beat show up before the verdict.
    pix.valid <= 1'b0;
    while (results_taken != pixels_sent) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (pending != 0) $error("%0d dithered beats never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
